// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the event message parser checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is held
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLKD_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/tev_pkg.sv
// ----------------------------------------------------------------------------
// tev_pkg
// shared types and constants of the text event message parser
// ----------------------------------------------------------------------------
package tev_pkg;

  localparam int COUNT_WIDTH  = 12;
  localparam int NUMBER_WIDTH = 31;
  localparam int MAXP_W       = 12;
  localparam int VAL_W        = NUMBER_WIDTH + 4;

  localparam logic [MAXP_W-1:0] MAXP_RESET = MAXP_W'(256);
  localparam logic [NUMBER_WIDTH-1:0] CNT_LIMIT =
    NUMBER_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);

  // token queue between classifier and parser
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // result kinds carried on tuser
  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // character codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  localparam int DATA_BITS = 8 + 8 + 3 * NUMBER_WIDTH + COUNT_WIDTH + 8 + COUNT_WIDTH;
  localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

  // classified input byte
  typedef struct packed {
    logic [7:0] raw;
    logic       is_digit;
    logic       is_space;
    logic       is_newline;
    logic [3:0] digit;
  } tok_t;

  // one result item
  typedef struct packed {
    logic [1:0]              status;
    logic [7:0]              origin;
    logic [7:0]              etype;
    logic [NUMBER_WIDTH-1:0] addr_start;
    logic [NUMBER_WIDTH-1:0] addr_end;
    logic [NUMBER_WIDTH-1:0] flags;
    logic [COUNT_WIDTH-1:0]  count;
    logic [7:0]              pbyte;
    logic [COUNT_WIDTH-1:0]  pindex;
    logic                    last;
  } res_t;

endpackage

// File: src/tev_classify.sv
// ----------------------------------------------------------------------------
// tev_classify
// front end: sorts each incoming byte into digit, space, newline or other
// ----------------------------------------------------------------------------
module tev_classify (
  input  logic [7:0]    in_byte,
  output tev_pkg::tok_t tok
);
  import tev_pkg::*;

  logic [7:0] diff;

  // digit value and character class
  always_comb begin
    diff           = in_byte - CH_ZERO;
    tok.raw        = in_byte;
    tok.is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    tok.is_space   = (in_byte == CH_SPACE);
    tok.is_newline = (in_byte == CH_NEWLINE);
    tok.digit      = diff[3:0];
  end

endmodule

// File: src/tev_queue.sv
// ----------------------------------------------------------------------------
// tev_queue
// short token queue that decouples the classifier from the parser
// ----------------------------------------------------------------------------
module tev_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tev_pkg::tok_t push_tok,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output tev_pkg::tok_t head_tok
);
  import tev_pkg::*;

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_tok  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// File: src/tev_parse.sv
// ----------------------------------------------------------------------------
// tev_parse
// back end: message state machine, number accumulation and result register
// ----------------------------------------------------------------------------
module tev_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tok_valid,
  input  tev_pkg::tok_t               tok,
  output logic                        tok_pop,
  input  logic [tev_pkg::MAXP_W-1:0]  max_payload,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tev_pkg::res_t               res
);
  import tev_pkg::*;

  localparam logic [2:0] PH_ORIGIN  = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_NUMBERS = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_NEWLINE = 3'd4;

  logic [2:0]              phase_r, phase_nxt;
  logic [NUMBER_WIDTH-1:0] acc_r, acc_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic [7:0]              origin_r, origin_nxt;
  logic [7:0]              etype_r, etype_nxt;
  logic [NUMBER_WIDTH-1:0] nums_r [3];
  logic [NUMBER_WIDTH-1:0] nums_nxt [3];
  logic [COUNT_WIDTH-1:0]  count_r, count_nxt;
  logic [COUNT_WIDTH-1:0]  pos_r, pos_nxt;
  logic                    skip_r, skip_nxt;
  logic                    out_valid_r;
  res_t                    res_r;

  logic                    fire;
  logic                    emit;
  logic [1:0]              emit_status;
  logic [VAL_W-1:0]        times_ten;
  logic                    too_big;
  logic                    bad;

  assign fire      = tok_valid && (!out_valid_r || res_ready);
  assign tok_pop   = fire;
  assign res_valid = out_valid_r;
  assign res       = res_r;

  // acc * 10 + digit as two shifted adds
  assign times_ten = (VAL_W'(acc_r) << 3) + (VAL_W'(acc_r) << 1) + VAL_W'(tok.digit);
  assign too_big   = (acc_r > NUMBER_WIDTH'(max_payload)) || (acc_r > CNT_LIMIT);

  // per-token state update
  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    idx_nxt     = idx_r;
    origin_nxt  = origin_r;
    etype_nxt   = etype_r;
    nums_nxt    = nums_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    skip_nxt    = skip_r;
    emit        = 1'b0;
    emit_status = ST_PAYLOAD;
    bad         = 1'b0;
    if (skip_r) begin
      if (tok.is_newline) begin
        skip_nxt  = 1'b0;
        phase_nxt = PH_ORIGIN;
      end
    end else begin
      case (phase_r)
        PH_ORIGIN: begin
          origin_nxt = tok.raw;
          etype_nxt  = '0;
          nums_nxt   = '{default: '0};
          count_nxt  = '0;
          acc_nxt    = '0;
          idx_nxt    = '0;
          pos_nxt    = '0;
          phase_nxt  = PH_TYPE;
        end
        PH_TYPE: begin
          etype_nxt = tok.raw;
          phase_nxt = PH_NUMBERS;
        end
        PH_NUMBERS: begin
          if (tok.is_digit) begin
            if (times_ten[VAL_W-1:NUMBER_WIDTH] != '0) begin
              bad = 1'b1;
            end else begin
              acc_nxt = times_ten[NUMBER_WIDTH-1:0];
            end
          end else if (!tok.is_space) begin
            bad = 1'b1;
          end else if (idx_r != 2'd3) begin
            nums_nxt[idx_r] = acc_r;
            idx_nxt         = idx_r + 2'd1;
            acc_nxt         = '0;
          end else if (too_big) begin
            bad = 1'b1;
          end else begin
            count_nxt = acc_r[COUNT_WIDTH-1:0];
            acc_nxt   = '0;
            pos_nxt   = '0;
            phase_nxt = (acc_r[COUNT_WIDTH-1:0] != '0) ? PH_PAYLOAD : PH_NEWLINE;
          end
        end
        PH_PAYLOAD: begin
          emit        = 1'b1;
          emit_status = ST_PAYLOAD;
          pos_nxt     = pos_r + 1'b1;
          if ((pos_r + 1'b1) >= count_r) begin
            phase_nxt = PH_NEWLINE;
          end
        end
        PH_NEWLINE: begin
          if (tok.is_newline) begin
            emit        = 1'b1;
            emit_status = ST_DONE;
            phase_nxt   = PH_ORIGIN;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          // unused phase codes restart as an origin byte
          origin_nxt = tok.raw;
          etype_nxt  = '0;
          nums_nxt   = '{default: '0};
          count_nxt  = '0;
          acc_nxt    = '0;
          idx_nxt    = '0;
          pos_nxt    = '0;
          phase_nxt  = PH_TYPE;
        end
      endcase
      // malformed message: report and resync at the next newline
      if (bad) begin
        emit        = 1'b1;
        emit_status = ST_BAD;
        phase_nxt   = PH_ORIGIN;
        acc_nxt     = '0;
        skip_nxt    = !tok.is_newline;
      end
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ORIGIN;
      acc_r    <= '0;
      idx_r    <= '0;
      origin_r <= '0;
      etype_r  <= '0;
      nums_r   <= '{default: '0};
      count_r  <= '0;
      pos_r    <= '0;
      skip_r   <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      idx_r    <= idx_nxt;
      origin_r <= origin_nxt;
      etype_r  <= etype_nxt;
      nums_r   <= nums_nxt;
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
      skip_r   <= skip_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, header fields as they stood before this token
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_r.status     <= emit_status;
      res_r.origin     <= origin_r;
      res_r.etype      <= etype_r;
      res_r.addr_start <= nums_r[0];
      res_r.addr_end   <= nums_r[1];
      res_r.flags      <= nums_r[2];
      res_r.count      <= count_r;
      res_r.pbyte      <= (emit_status == ST_PAYLOAD) ? tok.raw : 8'd0;
      res_r.pindex     <= (emit_status == ST_PAYLOAD) ? pos_r : '0;
      res_r.last       <= (emit_status != ST_PAYLOAD);
    end
  end

endmodule

// File: src/text_event_message_parser.sv
// ----------------------------------------------------------------------------
// text_event_message_parser
// byte-stream parser for text event messages with per-byte payload results
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the result side keeps up, and gives at
// most one result per byte. A byte is classified on entry, passes a
// two-entry token queue and is consumed by the parse state machine, whose
// result lands in an output register. When the output side is free, a
// byte's result is offered on out_tvalid once it has passed the queue entry
// and the output register. The combinational accumulate (acc * 10 + digit
// as shifted adds with an overflow check) sets the clock path. The queue
// keeps taking bytes while a finished result waits on out_tready, so input
// stalls only once the queue is full.
module text_event_message_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  // tdata: [7:0] in_byte
  input  logic [7:0]                  in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // tdata: [7:0] origin_code, [15:8] event_type, [46:16] addr_start,
  //        [77:47] addr_end, [108:78] flag_bits, [120:109] byte_count,
  //        [128:121] payload_byte, [140:129] payload_index, rest zero
  output logic [tev_pkg::TDATA_W-1:0] out_tdata,
  // tuser: [1:0] status
  output logic [1:0]                  out_tuser,
  output logic                        out_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_wr_en,
  input  logic [tev_pkg::MAXP_W-1:0]  cfg_wr_data
);
  import tev_pkg::*;

  logic [MAXP_W-1:0] max_payload_r;
  tok_t              in_tok;
  tok_t              head_tok;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  res_t              res;

  assign in_tready = !q_full;

  // max payload register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAXP_RESET;
    end else if (cfg_wr_en) begin
      max_payload_r <= cfg_wr_data;
    end
  end

  tev_classify u_classify (
    .in_byte (in_tdata),
    .tok     (in_tok)
  );

  tev_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_tok  (in_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  tev_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (q_not_empty),
    .tok         (head_tok),
    .tok_pop     (q_pop),
    .max_payload (max_payload_r),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  // pack result fields, lowest field first
  assign out_tdata = TDATA_W'({res.pindex, res.pbyte, res.count, res.flags,
                               res.addr_end, res.addr_start, res.etype, res.origin});
  assign out_tuser = res.status;
  assign out_tlast = res.last;

endmodule

// File: src/tev_checker.sv
// ----------------------------------------------------------------------------
// tev_checker
// port-level checks of the event message parser, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tev_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic [tev_pkg::TDATA_W-1:0] out_tdata,
  input logic [1:0]                  out_tuser,
  input logic                        out_tlast,
  input logic                        out_tvalid,
  input logic                        out_tready
);
  import tev_pkg::*;

  // a stalled result stays offered
  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `ASSERT_CLKD(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")

  // status is one of the three result kinds
  `ASSERT_CLKD(a_status_code, clk, rst_n, out_tvalid |-> (out_tuser == ST_PAYLOAD || out_tuser == ST_DONE || out_tuser == ST_BAD), "illegal status code")

  // tlast marks exactly the message-ending results
  `ASSERT_CLKD(a_last_match, clk, rst_n, out_tvalid |-> (out_tlast == (out_tuser != ST_PAYLOAD)), "tlast does not match status")

  // no result right after reset
  `ASSERT_CLKD_RST(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind text_event_message_parser tev_checker u_tev_checker (.*);

// File: dv/tev_parse_checker.sv
// ----------------------------------------------------------------------------
// tev_parse_checker
// watches both streams of the event message parser and checks every result
// ----------------------------------------------------------------------------
// Each request byte taken by the parser is run through a bit-true parse model
// kept here. That model has its own copy of the max_payload register, fed from
// the configuration port. Every result that the model produces is queued, and
// each result the parser hands out is compared field by field with the oldest
// one in the queue.
`timescale 1ns / 1ps

module tev_parse_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  in_tdata,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [tev_pkg::TDATA_W-1:0] out_tdata,
  input  logic [1:0]                  out_tuser,
  input  logic                        out_tlast,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_wr_en,
  input  logic [tev_pkg::MAXP_W-1:0]  cfg_wr_data,
  output int                          fail_count,
  output int                          pending,
  output int                          result_count,
  output int                          malformed_count
);
  import tev_pkg::*;

  localparam int NW = NUMBER_WIDTH;
  localparam int CW = COUNT_WIDTH;
  localparam longint unsigned NUM_LIMIT = (64'd1 << NUMBER_WIDTH) - 64'd1;

  // bit offsets of the result fields in tdata
  localparam int OFS_TYPE  = 8;
  localparam int OFS_START = 16;
  localparam int OFS_END   = OFS_START + NW;
  localparam int OFS_FLAGS = OFS_END + NW;
  localparam int OFS_COUNT = OFS_FLAGS + NW;
  localparam int OFS_PBYTE = OFS_COUNT + CW;
  localparam int OFS_PIDX  = OFS_PBYTE + 8;

  typedef enum logic [2:0] {
    AWAIT_ORIGIN,
    AWAIT_TYPE,
    IN_NUMBERS,
    IN_PAYLOAD,
    AWAIT_NEWLINE
  } parse_phase_e;

  // parse model state
  parse_phase_e    phase;
  logic [NW-1:0]   acc;
  int              num_idx;
  logic [7:0]      org;
  logic [7:0]      typ;
  logic [NW-1:0]   nums [3];
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   pos;
  bit              skipping;
  logic [MAXP_W-1:0] max_payload;

  res_t parsed_results [$];
  int   mismatches;
  int   checked;
  int   malformed_seen;

  // result built from the header fields parsed so far
  function automatic res_t make_result(input logic [1:0] st, input logic [7:0] pb,
                                       input logic [CW-1:0] pi, input logic lst);
    res_t r;
    r.status     = st;
    r.origin     = org;
    r.etype      = typ;
    r.addr_start = nums[0];
    r.addr_end   = nums[1];
    r.flags      = nums[2];
    r.count      = cnt;
    r.pbyte      = pb;
    r.pindex     = pi;
    r.last       = lst;
    return r;
  endfunction

  // format error: skip up to a newline unless the offending byte is one
  function automatic res_t flag_malformed(input logic [7:0] b);
    res_t r;
    r        = make_result(ST_BAD, 8'd0, '0, 1'b1);
    phase    = AWAIT_ORIGIN;
    acc      = '0;
    skipping = (b != CH_NEWLINE);
    return r;
  endfunction

  // one byte through the parser, returns 1 when it yields a result
  function automatic bit parse_byte(input logic [7:0] b, output res_t r);
    longint unsigned v;
    r = '0;
    if (skipping) begin
      if (b == CH_NEWLINE) begin
        skipping = 1'b0;
        phase    = AWAIT_ORIGIN;
      end
      return 1'b0;
    end
    case (phase)
      AWAIT_ORIGIN: begin
        org     = b;
        typ     = '0;
        nums[0] = '0;
        nums[1] = '0;
        nums[2] = '0;
        cnt     = '0;
        acc     = '0;
        num_idx = 0;
        pos     = '0;
        phase   = AWAIT_TYPE;
        return 1'b0;
      end
      AWAIT_TYPE: begin
        typ   = b;
        phase = IN_NUMBERS;
        return 1'b0;
      end
      IN_NUMBERS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          v = 64'(acc) * 64'd10 + 64'(b - CH_ZERO);
          if (v > NUM_LIMIT) begin
            r = flag_malformed(b);
            return 1'b1;
          end
          acc = v[NW-1:0];
          return 1'b0;
        end
        if (b != CH_SPACE) begin
          r = flag_malformed(b);
          return 1'b1;
        end
        if (num_idx < 3) begin
          nums[num_idx] = acc;
          num_idx++;
          acc = '0;
          return 1'b0;
        end
        // fourth number is the payload count
        if (64'(acc) > 64'(max_payload) || 64'(acc) > 64'(CNT_LIMIT)) begin
          r = flag_malformed(b);
          return 1'b1;
        end
        cnt   = acc[CW-1:0];
        acc   = '0;
        pos   = '0;
        phase = (cnt != '0) ? IN_PAYLOAD : AWAIT_NEWLINE;
        return 1'b0;
      end
      IN_PAYLOAD: begin
        r   = make_result(ST_PAYLOAD, b, pos, 1'b0);
        pos = pos + 1'b1;
        if (pos >= cnt) phase = AWAIT_NEWLINE;
        return 1'b1;
      end
      default: begin
        if (b != CH_NEWLINE) begin
          r = flag_malformed(b);
          return 1'b1;
        end
        r     = make_result(ST_DONE, 8'd0, '0, 1'b1);
        phase = AWAIT_ORIGIN;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // compare, then config, then prediction, all on the same edge
  always @(posedge clk) begin : monitor
    res_t want;
    res_t fresh;
    if (!rst_n) begin
      phase       = AWAIT_ORIGIN;
      acc         = '0;
      num_idx     = 0;
      org         = '0;
      typ         = '0;
      nums[0]     = '0;
      nums[1]     = '0;
      nums[2]     = '0;
      cnt         = '0;
      pos         = '0;
      skipping    = 1'b0;
      max_payload = MAXP_RESET;
      parsed_results.delete();
      mismatches     = 0;
      checked        = 0;
      malformed_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (parsed_results.size() == 0) begin
          $error("result with no request pending: status %0d", out_tuser);
          mismatches++;
        end else begin
          want = parsed_results.pop_front();
          checked++;
          if (want.status == ST_BAD) malformed_seen++;
          check_field("status", want.status, out_tuser);
          check_field("origin_code", want.origin, out_tdata[7:0]);
          check_field("event_type", want.etype, out_tdata[OFS_TYPE +: 8]);
          check_field("addr_start", want.addr_start, out_tdata[OFS_START +: NW]);
          check_field("addr_end", want.addr_end, out_tdata[OFS_END +: NW]);
          check_field("flag_bits", want.flags, out_tdata[OFS_FLAGS +: NW]);
          check_field("byte_count", want.count, out_tdata[OFS_COUNT +: CW]);
          check_field("payload_byte", want.pbyte, out_tdata[OFS_PBYTE +: 8]);
          check_field("payload_index", want.pindex, out_tdata[OFS_PIDX +: CW]);
          check_field("last", want.last, out_tlast);
          check_field("tdata padding", 0, out_tdata[TDATA_W-1:DATA_BITS]);
        end
      end
      if (cfg_wr_en) max_payload = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (parse_byte(in_tdata, fresh)) parsed_results.push_back(fresh);
      end
    end
    fail_count      <= mismatches;
    pending         <= parsed_results.size();
    result_count    <= checked;
    malformed_count <= malformed_seen;
  end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// stream test of the text event message parser
// ----------------------------------------------------------------------------
// Sends a directed set of messages that hit the format corner cases, then
// about fifteen hundred bytes of random messages, most well formed and the
// rest broken or plain noise, under six max_payload settings including both
// extremes. Both stream sides idle at random, and once the result side holds
// off long enough for the parser to stall its input. The checker module does
// all the comparing; this module makes requests and gives the verdict.
`timescale 1ns / 1ps

module tb;
  import tev_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BYTES    = 260;

  logic                 clk;
  logic                 rst_n;
  logic [7:0]           in_tdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [TDATA_W-1:0]   out_tdata;
  logic [1:0]           out_tuser;
  logic                 out_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic                 cfg_wr_en;
  logic [MAXP_W-1:0]    cfg_wr_data;

  int fail_count;
  int pending;
  int result_count;
  int malformed_count;

  logic [7:0]        msg_bytes [$];
  logic [MAXP_W-1:0] cur_max;
  bit                tx_gappy;
  bit                hold_armed;
  int                sent_bytes;
  int                n_messages;
  int                n_settings;
  int                idle_cycles;

  text_event_message_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tev_parse_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .result_count    (result_count),
    .malformed_count (malformed_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    msg_bytes.push_back(b);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endfunction

  // any byte that is neither a digit nor a space
  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE);
    return b;
  endfunction

  // a valid number, sometimes empty, sometimes the largest one
  function automatic void put_number();
    case ($urandom_range(0, 9))
      0: ;
      1: put_text("2147483647");
      2: put_text($sformatf("00%0d", $urandom_range(0, 9)));
      3, 4, 5: put_text($sformatf("%0d", $urandom_range(0, 99)));
      default: put_text($sformatf("%0d", $urandom_range(0, 32'h7fffffff)));
    endcase
  endfunction

  function automatic void put_header(input int count);
    put_byte(8'($urandom_range(0, 255)));
    put_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < 3; i++) begin
      put_number();
      put_text(" ");
    end
    put_text($sformatf("%0d ", count));
  endfunction

  function automatic void put_payload(input int count);
    for (int i = 0; i < count; i++) put_byte(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_gappy ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sent_bytes++;
  endtask

  task automatic send_message();
    n_messages++;
    while (msg_bytes.size() != 0) send_byte(msg_bytes.pop_front());
  endtask

  // stop requests, wait for all results and for the pipe to empty
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [MAXP_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_max = v;
    n_settings++;
  endtask

  // count exactly at the limit (for limits up to 64) and one above it
  task automatic send_limit_messages();
    if (cur_max <= 64) begin
      put_header(cur_max);
      put_payload(cur_max);
      put_text("\n");
      send_message();
    end
    put_header(cur_max + 1);
    put_text("9\n");
    send_message();
  endtask

  // mostly well formed messages, the rest broken in one way or noise
  task automatic send_random_message();
    int kind;
    int hi;
    int count;
    int bad_at;
    kind   = $urandom_range(0, 99);
    bad_at = $urandom_range(0, 2);
    tx_gappy = ($urandom_range(0, 3) != 0);
    if (kind >= 95) begin
      put_payload($urandom_range(1, 12));
      put_text("\n");
      send_message();
      return;
    end
    hi = (cur_max < 8) ? cur_max : 8;
    if ($urandom_range(0, 9) == 0) hi = (cur_max < 60) ? cur_max : 60;
    count = $urandom_range(0, hi);
    put_byte(8'($urandom_range(0, 255)));
    put_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < 3; i++) begin
      if (kind >= 80 && kind < 84 && i == bad_at)
        put_text($sformatf("%0d", 64'd2147483648 + 64'($urandom_range(0, 99999))));
      else
        put_number();
      if (kind >= 84 && kind < 88 && i == bad_at) put_byte(non_digit());
      put_text(" ");
    end
    if (kind >= 88 && kind < 91) begin
      put_text($sformatf("%0d ", cur_max + 1 + $urandom_range(0, 3)));
      count = 0;
    end else begin
      put_text($sformatf("%0d ", count));
    end
    put_payload(count);
    if (kind >= 91 && kind < 95) begin
      do put_byte(8'($urandom_range(0, 255)));
      while (msg_bytes[msg_bytes.size()-1] == CH_NEWLINE);
      if ($urandom_range(0, 1) != 0) put_text("\n");
    end else begin
      put_text("\n");
    end
    send_message();
  endtask

  // result side: random stalls, calm stretches, one long hold-off on request
  initial begin : receiver
    int stall_left;
    int rx_cycles;
    bit hold_done;
    stall_left = 0;
    rx_cycles  = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (hold_armed && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if ((rx_cycles / 250) % 3 == 0) begin
        out_tready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // no request or result moving for too long means a hang
  always @(posedge clk) begin
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [MAXP_W-1:0] settings [5];
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    idle_cycles <= 0;
    hold_armed  = 1'b0;
    tx_gappy    = 1'b0;
    sent_bytes  = 0;
    n_messages  = 0;
    n_settings  = 1;
    cur_max     = MAXP_RESET;
    settings[0] = '0;
    settings[1] = '1;
    settings[2] = 12'd1;
    settings[3] = 12'($urandom_range(2, 4094));
    settings[4] = 12'd255;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // largest numbers, extreme header bytes, newline inside the payload
    put_byte(8'hff);
    put_byte(8'h00);
    put_text("2147483647 2147483647 2147483647 2 ");
    put_byte(CH_NEWLINE);
    put_byte(8'hff);
    put_text("\n");
    send_message();
    // newline as header bytes, all numbers empty, zero count
    put_text("\n\n    \n");
    send_message();
    // non-digit inside a number, rest skipped to the newline
    put_text("ab12x45 9 \n");
    send_message();
    // number one past the largest
    put_text("ab2147483648 \n");
    send_message();
    // count above the reset limit
    put_text("ab1 2 3 257 \n");
    send_message();
    // payload followed by something other than a newline
    put_text("ab0 0 0 1 Zq\n");
    send_message();
    // newline ends a number early, no skip after it
    put_text("ab12\n");
    send_message();
    // leading zeros
    put_text("ab007 0 0 0 \n");
    send_message();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        write_max_payload(settings[p-1]);
        send_limit_messages();
      end
      if (p == 2) begin
        // long payload while the result side holds off
        tx_gappy   = 1'b0;
        hold_armed = 1'b1;
        put_header(120);
        put_payload(120);
        put_text("\n");
        send_message();
      end
      while (sent_bytes < (p + 1) * PHASE_BYTES) send_random_message();
    end

    settle();
    $display("run covered %0d bytes in %0d messages under %0d max_payload settings",
             sent_bytes, n_messages, n_settings);
    $display("%0d results checked, %0d of them malformed", result_count, malformed_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: text_event_message_parser.f
+incdir+src
src/tev_pkg.sv
src/tev_classify.sv
src/tev_queue.sv
src/tev_parse.sv
src/text_event_message_parser.sv
src/tev_checker.sv
dv/tev_parse_checker.sv
dv/tb.sv
